@@ src/clr_pkg.sv @@
// Shared types, codes and constants of the clipped line, rectangle and circle rasterizer.
package clr_pkg;

  localparam int CW = 18;
  typedef logic signed [CW-1:0] crd_t;

  localparam logic [2:0] CMD_SPAN = 3'd0;
  localparam logic [2:0] CMD_LINE = 3'd1;
  localparam logic [2:0] CMD_RECT = 3'd2;
  localparam logic [2:0] CMD_CIRC = 3'd3;
  localparam logic [2:0] CMD_READ = 3'd4;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_PARAM = 2'd1;
  localparam logic [1:0] STS_MODE  = 2'd2;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MONO   = 2'd2;

  localparam int D_INIT   = 3;
  localparam int D_MUL    = 4;
  localparam int D_STEP_A = 6;
  localparam int D_STEP_B = 10;

  typedef enum logic [2:0] {
    RS_SPAN,
    RS_ROW,
    RS_EDGE,
    RS_CIRC,
    RS_POINT
  } run_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_ADDR,
    S_RD_DATA,
    S_SPAN,
    S_RECT,
    S_CIRC,
    S_CIRC_UPD,
    S_LINE,
    S_LINE_STEP,
    S_RUN_RD,
    S_RUN_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     clr_wr;
    logic     clr_inc;
    logic     rd_word;
    logic     capture;
    logic     run_load;
    run_sel_t run_sel;
    logic     pix_wr;
    logic     pos_inc;
    logic     k_inc;
    logic     k_clr;
    logic     row_inc;
    logic     circ_upd;
    logic     line_step;
  } ctl_t;

  typedef struct packed {
    logic [2:0] ld_cmd;
    logic       ld_ok;
    logic       clr_last;
    logic       run_nonempty;
    logic       run_last;
    logic       fill;
    logic [2:0] k;
    logic       row_ok;
    logic       circ_go;
    logic       line_end;
  } sts_t;

endpackage

@@ src/clr_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module clr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/clr_datapath.sv @@
// Datapath: configuration, command registers, primitive generators, run clipper and frame buffer.
module clr_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  clr_pkg::ctl_t      ctl,
  output clr_pkg::sts_t      sts,
  input  logic [2:0]         cmd,
  input  logic signed [15:0] x_a,
  input  logic signed [15:0] y_a,
  input  logic signed [15:0] x_b,
  input  logic signed [15:0] y_b,
  input  logic signed [15:0] span_length,
  input  logic [7:0]         direction,
  input  logic [7:0]         radius,
  input  logic [7:0]         color,
  input  logic [7:0]         fill,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  output logic [1:0]         status,
  output logic [31:0]        read_data
);
  import clr_pkg::*;

  localparam int WPR   = (MAX_WIDTH + 31) / 32;
  localparam int DEPTH = WPR * MAX_HEIGHT;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
  localparam int PW    = XW > YW ? XW : YW;

  logic [8:0] panel_width;
  logic [8:0] panel_height;
  logic       mono_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= 9'd256;
      panel_height <= 9'd256;
      mono_mode    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  panel_width  <= cfg_data;
        REG_HEIGHT: panel_height <= cfg_data;
        REG_MONO:   mono_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  crd_t clip_w, clip_h;
  assign clip_w = (panel_width < MAX_WIDTH) ? crd_t'(panel_width) : crd_t'(MAX_WIDTH);
  assign clip_h = (panel_height < MAX_HEIGHT) ? crd_t'(panel_height) : crd_t'(MAX_HEIGHT);

  crd_t xa_in, ya_in, xb_in, yb_in, yl_in;
  assign xa_in = crd_t'(x_a);
  assign ya_in = crd_t'(y_a);
  assign xb_in = crd_t'(x_b);
  assign yb_in = crd_t'(y_b);
  assign yl_in = (ya_in < yb_in) ? ya_in : yb_in;

  logic [1:0] ld_status;
  always_comb begin
    ld_status = STS_OK;
    if (cmd == CMD_READ) begin
      if (xa_in < 0 || ya_in < 0 || xa_in >= crd_t'(MAX_WIDTH) ||
          ya_in >= crd_t'(MAX_HEIGHT)) begin
        ld_status = STS_PARAM;
      end
    end else if (cmd > CMD_READ) begin
      ld_status = STS_PARAM;
    end else if (!mono_mode) begin
      ld_status = STS_MODE;
    end else if (color > 8'd1) begin
      ld_status = STS_PARAM;
    end else if ((cmd == CMD_RECT || cmd == CMD_CIRC) && fill > 8'd1) begin
      ld_status = STS_PARAM;
    end else if (cmd == CMD_SPAN && direction > 8'd3) begin
      ld_status = STS_PARAM;
    end
  end

  logic [1:0]         status_q;
  logic [31:0]        data_q;
  logic               pen;
  logic               fill_q;
  logic [1:0]         dir_q;
  crd_t               len_q, xa_q, ya_q, xb_q, yb_q, row;
  logic [2:0]         k;
  logic signed [9:0]  ca, cb;
  logic signed [15:0] cd;
  crd_t               lx, ly;
  logic signed [19:0] ldx, ldy, lerr;
  logic               lsx, lsy;
  logic [31:0]        rdata;

  crd_t ldx_in, ldy_in;
  assign ldx_in = (xb_in >= xa_in) ? xb_in - xa_in : xa_in - xb_in;
  assign ldy_in = (yb_in >= ya_in) ? yb_in - ya_in : ya_in - yb_in;

  logic signed [19:0] e2;
  logic               c1, c2;
  assign e2 = lerr <<< 1;
  assign c1 = e2 > -ldy;
  assign c2 = e2 < ldx;

  logic signed [9:0] a1, b1;
  assign a1 = ca + 10'sd1;
  assign b1 = cb - 10'sd1;

  crd_t xl, xh, yl, yh;
  assign xl = (xa_q < xb_q) ? xa_q : xb_q;
  assign xh = (xa_q < xb_q) ? xb_q : xa_q;
  assign yl = (ya_q < yb_q) ? ya_q : yb_q;
  assign yh = (ya_q < yb_q) ? yb_q : ya_q;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      status_q <= ld_status;
      data_q   <= '0;
      pen      <= color[0];
      fill_q   <= fill[0];
      dir_q    <= direction[1:0];
      len_q    <= crd_t'(span_length);
      xa_q     <= xa_in;
      ya_q     <= ya_in;
      xb_q     <= xb_in;
      yb_q     <= yb_in;
      row      <= (yl_in < 0) ? '0 : yl_in;
      ca       <= '0;
      cb       <= 10'($unsigned(radius));
      cd       <= 16'(D_INIT) - {7'd0, radius, 1'b0};
      lx       <= xa_in;
      ly       <= ya_in;
      ldx      <= 20'(ldx_in);
      ldy      <= 20'(ldy_in);
      lerr     <= 20'(ldx_in) - 20'(ldy_in);
      lsx      <= xa_in < xb_in;
      lsy      <= ya_in < yb_in;
    end
    if (ctl.capture) begin
      data_q <= rdata;
    end
    if (ctl.row_inc) begin
      row <= row + crd_t'(1);
    end
    if (ctl.circ_upd) begin
      ca <= a1;
      if (cd < 0) begin
        cd <= cd + 16'(a1) * 16'(D_MUL) + 16'(D_STEP_A);
      end else begin
        cb <= b1;
        cd <= cd + 16'(a1 - b1) * 16'(D_MUL) + 16'(D_STEP_B);
      end
    end
    if (ctl.line_step) begin
      lerr <= lerr - (c1 ? ldy : 20'sd0) + (c2 ? ldx : 20'sd0);
      if (c1) begin
        lx <= lsx ? lx + crd_t'(1) : lx - crd_t'(1);
      end
      if (c2) begin
        ly <= lsy ? ly + crd_t'(1) : ly - crd_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (ctl.load || ctl.k_clr) begin
      k <= '0;
    end else if (ctl.k_inc) begin
      k <= k + 3'd1;
    end
  end

  logic g_h;
  crd_t g_fix, g_lo, g_hi;
  crd_t aa, bb, cu, cv;
  always_comb begin
    g_h   = 1'b1;
    g_fix = '0;
    g_lo  = '0;
    g_hi  = '0;
    aa    = crd_t'(ca);
    bb    = crd_t'(cb);
    cu    = k[1] ? aa : bb;
    cv    = k[1] ? bb : aa;
    case (ctl.run_sel)
      RS_SPAN: begin
        case (dir_q)
          DIR_RIGHT: begin
            g_fix = ya_q;
            g_lo  = xa_q;
            g_hi  = xa_q + len_q - crd_t'(1);
          end
          DIR_DOWN: begin
            g_h   = 1'b0;
            g_fix = xa_q;
            g_lo  = ya_q;
            g_hi  = ya_q + len_q - crd_t'(1);
          end
          DIR_LEFT: begin
            g_fix = ya_q;
            g_lo  = xa_q - len_q + crd_t'(1);
            g_hi  = xa_q;
          end
          default: begin
            g_h   = 1'b0;
            g_fix = xa_q;
            g_lo  = ya_q - len_q + crd_t'(1);
            g_hi  = ya_q;
          end
        endcase
      end
      RS_ROW: begin
        g_fix = row;
        g_lo  = xl;
        g_hi  = xh;
      end
      RS_EDGE: begin
        case (k[1:0])
          2'd0: begin
            g_fix = yl;
            g_lo  = xl;
            g_hi  = xh;
          end
          2'd1: begin
            g_fix = yh;
            g_lo  = xl;
            g_hi  = xh;
          end
          2'd2: begin
            g_h   = 1'b0;
            g_fix = xl;
            g_lo  = yl + crd_t'(1);
            g_hi  = yh - crd_t'(1);
          end
          default: begin
            g_h   = 1'b0;
            g_fix = xh;
            g_lo  = yl + crd_t'(1);
            g_hi  = yh - crd_t'(1);
          end
        endcase
      end
      RS_CIRC: begin
        if (fill_q) begin
          g_fix = k[0] ? ya_q - cv : ya_q + cv;
          g_lo  = xa_q - cu;
          g_hi  = xa_q + cu;
        end else begin
          g_fix = k[2] ? ya_q - cv : ya_q + cv;
          g_lo  = k[0] ? xa_q - cu : xa_q + cu;
          g_hi  = g_lo;
        end
      end
      RS_POINT: begin
        g_fix = ly;
        g_lo  = lx;
        g_hi  = lx;
      end
      default: ;
    endcase
  end

  crd_t lim, flim, lo_c, hi_c;
  always_comb begin
    lim  = g_h ? clip_w : clip_h;
    flim = g_h ? clip_h : clip_w;
    lo_c = (g_lo < 0) ? '0 : g_lo;
    hi_c = (g_hi > lim - crd_t'(1)) ? lim - crd_t'(1) : g_hi;
  end

  logic          run_h;
  logic [PW-1:0] run_fix, pos, run_hi;

  always_ff @(posedge clk) begin
    if (ctl.run_load) begin
      run_h   <= g_h;
      run_fix <= g_fix[PW-1:0];
      pos     <= lo_c[PW-1:0];
      run_hi  <= hi_c[PW-1:0];
    end else if (ctl.pos_inc) begin
      pos <= pos + 1'b1;
    end
  end

  logic [XW-1:0] px;
  logic [YW-1:0] py;
  logic [AW-1:0] pix_addr, word_addr, clr_addr;
  logic [31:0]   bit_mask, pix_word;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata;

  assign px        = XW'(run_h ? pos : run_fix);
  assign py        = YW'(run_h ? run_fix : pos);
  assign pix_addr  = AW'(32'(py) * WPR + 32'(px >> 5));
  assign word_addr = AW'(32'(ya_q[YW-1:0]) * WPR + 32'(xa_q[XW-1:0] >> 5));
  assign bit_mask  = 32'd1 << px[4:0];
  assign pix_word  = pen ? (rdata | bit_mask) : (rdata & ~bit_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_inc) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign ram_we    = ctl.clr_wr | ctl.pix_wr;
  assign ram_waddr = ctl.clr_wr ? clr_addr : pix_addr;
  assign ram_wdata = ctl.clr_wr ? '0 : pix_word;
  assign ram_raddr = ctl.rd_word ? word_addr : pix_addr;

  clr_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_fb (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  assign sts.ld_cmd       = cmd;
  assign sts.ld_ok        = ld_status == STS_OK;
  assign sts.clr_last     = clr_addr == AW'(DEPTH - 1);
  assign sts.run_nonempty = g_fix >= 0 && g_fix < flim && lo_c <= hi_c;
  assign sts.run_last     = pos == run_hi;
  assign sts.fill         = fill_q;
  assign sts.k            = k;
  assign sts.row_ok       = row <= yh && row <= clip_h - crd_t'(1);
  assign sts.circ_go      = ca <= cb;
  assign sts.line_end     = lx == xb_q && ly == yb_q;

  assign status    = status_q;
  assign read_data = data_q;

endmodule

@@ src/clr_ctrl.sv @@
// Controller: sequences the clear pass, commands, primitive runs and result strobe.
module clr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output clr_pkg::ctl_t ctl,
  input  clr_pkg::sts_t sts
);
  import clr_pkg::*;

  state_t state, state_next;
  state_t ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    ctl        = '0;
    ctl.run_sel = RS_SPAN;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      S_CLEAR: begin
        ctl.clr_wr  = 1'b1;
        ctl.clr_inc = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load = 1'b1;
          if (!sts.ld_ok) begin
            state_next = S_DONE;
          end else begin
            case (sts.ld_cmd)
              CMD_READ: state_next = S_RD_ADDR;
              CMD_SPAN: state_next = S_SPAN;
              CMD_LINE: state_next = S_LINE;
              CMD_RECT: state_next = S_RECT;
              CMD_CIRC: state_next = S_CIRC;
              default:  state_next = S_DONE;
            endcase
          end
        end
      end
      S_RD_ADDR: begin
        ctl.rd_word = 1'b1;
        state_next  = S_RD_DATA;
      end
      S_RD_DATA: begin
        ctl.capture = 1'b1;
        state_next  = S_DONE;
      end
      S_SPAN: begin
        ctl.run_load = 1'b1;
        ctl.run_sel  = RS_SPAN;
        ret_next     = S_DONE;
        state_next   = sts.run_nonempty ? S_RUN_RD : S_DONE;
      end
      S_RECT: begin
        if (sts.fill) begin
          if (sts.row_ok) begin
            ctl.run_load = 1'b1;
            ctl.run_sel  = RS_ROW;
            ctl.row_inc  = 1'b1;
            ret_next     = S_RECT;
            state_next   = sts.run_nonempty ? S_RUN_RD : S_RECT;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          ctl.run_load = 1'b1;
          ctl.run_sel  = RS_EDGE;
          ctl.k_inc    = 1'b1;
          ret_next     = (sts.k == 3'd3) ? S_DONE : S_RECT;
          state_next   = sts.run_nonempty ? S_RUN_RD : ret_next;
        end
      end
      S_CIRC: begin
        if (!sts.circ_go) begin
          state_next = S_DONE;
        end else begin
          ctl.run_load = 1'b1;
          ctl.run_sel  = RS_CIRC;
          if ((sts.fill && sts.k == 3'd3) || (!sts.fill && sts.k == 3'd7)) begin
            ctl.k_clr = 1'b1;
            ret_next  = S_CIRC_UPD;
          end else begin
            ctl.k_inc = 1'b1;
            ret_next  = S_CIRC;
          end
          state_next = sts.run_nonempty ? S_RUN_RD : ret_next;
        end
      end
      S_CIRC_UPD: begin
        ctl.circ_upd = 1'b1;
        state_next   = S_CIRC;
      end
      S_LINE: begin
        ctl.run_load = 1'b1;
        ctl.run_sel  = RS_POINT;
        ret_next     = S_LINE_STEP;
        state_next   = sts.run_nonempty ? S_RUN_RD : S_LINE_STEP;
      end
      S_LINE_STEP: begin
        if (sts.line_end) begin
          state_next = S_DONE;
        end else begin
          ctl.line_step = 1'b1;
          state_next    = S_LINE;
        end
      end
      S_RUN_RD: begin
        state_next = S_RUN_WR;
      end
      S_RUN_WR: begin
        ctl.pix_wr = 1'b1;
        if (sts.run_last) begin
          state_next = ret;
        end else begin
          ctl.pos_inc = 1'b1;
          state_next  = S_RUN_RD;
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ src/clipped_line_rect_circle_rasterizer.sv @@
// Top level of the clipped line, rectangle and circle rasterizer for a 1-bit frame buffer.
// After reset the block clears all ((MAX_WIDTH+31)/32)*MAX_HEIGHT words of its frame buffer
// (2048 at the defaults), one word a cycle, and holds busy high meanwhile;
// configuration writes are taken at any time. Each command yields exactly one item on
// status and read_data, marked by done for one cycle, and the receiver cannot stall it.
// Every pixel is a read-modify-write of the frame buffer word, in a read state and then a
// write state, and each horizontal or vertical run is loaded before its pixels are drawn.
// A read command addresses the word and then captures it; a rejected command goes to done.
module clipped_line_rect_circle_rasterizer #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic signed [15:0] x_a,
  input  logic signed [15:0] y_a,
  input  logic signed [15:0] x_b,
  input  logic signed [15:0] y_b,
  input  logic signed [15:0] span_length,
  input  logic [7:0]         direction,
  input  logic [7:0]         radius,
  input  logic [7:0]         color,
  input  logic [7:0]         fill,
  output logic               done,
  output logic [1:0]         status,
  output logic [31:0]        read_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);
  import clr_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  clr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .ctl  (ctl),
    .sts  (sts)
  );

  clr_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cmd        (cmd),
    .x_a        (x_a),
    .y_a        (y_a),
    .x_b        (x_b),
    .y_b        (y_b),
    .span_length(span_length),
    .direction  (direction),
    .radius     (radius),
    .color      (color),
    .fill       (fill),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .status     (status),
    .read_data  (read_data)
  );

endmodule
